// ----- sv/sfs_pkg.sv -----
// shared constants, types and command/status structs for the floor search unit
package sfs_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ID_WIDTH = 32;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_CMP   = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic load_query;
    logic read;
    logic compare;
  } sfs_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
  } sfs_status_t;

endpackage

// ----- sv/sfs_ctrl.sv -----
// controller state machine for the floor search unit
module sfs_ctrl import sfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  operation_i,
  input  sfs_status_t status_i,
  output sfs_cmd_t    cmd_o,
  output logic        busy,
  output logic        result_strobe_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op_e'(operation_i) == OP_QUERY)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = status_i.range_empty ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    busy            = 1'b1;
    result_strobe_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          case (op_e'(operation_i))
            OP_CLEAR:  cmd_o.clear      = 1'b1;
            OP_APPEND: cmd_o.append     = 1'b1;
            OP_QUERY:  cmd_o.load_query = 1'b1;
            default:   cmd_o            = '0;
          endcase
        end
      end
      ST_PROBE: begin
        cmd_o.read = 1'b1;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
      end
      ST_DONE: begin
        result_strobe_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_IDLE)
    else $error("result state not left after one cycle");

  a_query_starts_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(operation_i) == OP_QUERY) |=> state_q == ST_PROBE)
    else $error("accepted query did not start probing");

  a_strobe_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> ($past(state_q) == ST_PROBE || $past(state_q) == ST_CMP))
    else $error("result strobe without a finished search");

endmodule

// ----- sv/sfs_datapath.sv -----
// id storage, search bounds and candidate registers for the floor search unit
module sfs_datapath import sfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ID_WIDTH-1:0] value_i,
  input  sfs_cmd_t            cmd_i,
  output sfs_status_t         status_o,
  output logic                found_o,
  output logic [ID_WIDTH-1:0] floor_id_o
);

  logic [ID_WIDTH-1:0] mem [DEPTH];
  logic [ID_WIDTH-1:0] rdata_q;
  logic [ID_WIDTH-1:0] target_q;
  logic [ID_WIDTH-1:0] best_q, best_d;
  logic                found_q, found_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    mid_q;
  logic                full;
  logic                hit;
  logic                below;

  // hi_q is one past the last entry of the open range
  assign mid   = lo_q + ((hi_q - lo_q - CNT_W'(1)) >> 1);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign hit   = (rdata_q == target_q);
  assign below = (rdata_q < target_q);

  assign status_o.range_empty = (lo_q >= hi_q);
  assign status_o.hit         = hit;
  assign found_o              = found_q;
  assign floor_id_o           = best_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[count_q[ADDR_W-1:0]] <= value_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[mid[ADDR_W-1:0]];
      mid_q   <= mid;
    end
    if (cmd_i.load_query) begin
      target_q <= value_i;
    end
  end

  always_comb begin
    count_d = count_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    best_d  = best_q;
    found_d = found_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append && !full) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.load_query) begin
      lo_d    = '0;
      hi_d    = count_q;
      best_d  = '0;
      found_d = 1'b0;
    end else if (cmd_i.compare) begin
      if (hit) begin
        best_d  = rdata_q;
        found_d = 1'b1;
      end else if (below) begin
        best_d  = rdata_q;
        found_d = 1'b1;
        lo_d    = mid_q + CNT_W'(1);
      end else begin
        hi_d = mid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      best_q  <= best_d;
      found_q <= found_d;
    end
  end

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("item count above capacity");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> best_q == '0)
    else $error("nonzero floor id without a candidate");

endmodule

// ----- sv/sorted_floor_search_unit.sv -----
// top level of the sorted id list with floor search
// Usage:
//   Commands enter on start/operation_i/value_i and are taken on a clock edge
//   where start is high and busy is low. operation_i: clear list, append id,
//   or floor query on value_i; the unused code is taken and ignored.
//   Clear and append finish in the cycle of the transfer and give no result;
//   busy stays low, so the next command can follow at once. An append to a
//   full list is dropped.
//   A query raises busy and runs a binary search over one single-port id
//   memory with registered read data: each probe is a read and then a
//   compare. The search ends on an exact match or on an empty range, and
//   result_strobe_o then rises; there are at most clog2(count)+1 probes.
//   The result (found_o, floor_id_o) is valid for the single cycle that
//   result_strobe_o is high; the receiver cannot stall it. floor_id_o is zero
//   when found_o is low.
//   Reset empties the list and returns the unit to idle; memory contents are
//   not cleared and need no pass.
module sorted_floor_search_unit import sfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [ID_WIDTH-1:0] value_i,
  output logic                result_strobe_o,
  output logic                found_o,
  output logic [ID_WIDTH-1:0] floor_id_o
);

  sfs_cmd_t    cmd;
  sfs_status_t status;

  sfs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .operation_i     (operation_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .busy            (busy),
    .result_strobe_o (result_strobe_o)
  );

  sfs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .found_o    (found_o),
    .floor_id_o (floor_id_o)
  );

endmodule

// ----- verif/sfs_floor_checker.sv -----
// checker for the floor search unit: mirrors the id list and compares every query result
`timescale 1ns / 100ps
module sfs_floor_checker import sfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          operation_i,
  input  logic [ID_WIDTH-1:0] value_i,
  input  logic                result_strobe_i,
  input  logic                found_i,
  input  logic [ID_WIDTH-1:0] floor_id_i,
  output int                  error_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic                found;
    logic [ID_WIDTH-1:0] floor_id;
  } floor_answer_t;

  logic [ID_WIDTH-1:0] id_list [DEPTH];
  logic [CNT_W-1:0]    list_len;
  floor_answer_t       floor_answers_q [$];
  floor_answer_t       oldest_answer;

  // binary search with the same probe order as the unit
  function automatic floor_answer_t predict_floor(logic [ID_WIDTH-1:0] target);
    int            lo;
    int            hi;
    int            mid;
    floor_answer_t ans;
    lo  = 0;
    hi  = int'(list_len) - 1;
    ans = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (id_list[mid] == target) begin
        ans.found    = 1'b1;
        ans.floor_id = id_list[mid];
        return ans;
      end
      if (id_list[mid] < target) begin
        ans.found    = 1'b1;
        ans.floor_id = id_list[mid];
        lo           = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = '0;
      floor_answers_q.delete();
      error_count_o = 0;
    end else begin
      if (result_strobe_i) begin
        if (floor_answers_q.size() == 0) begin
          $error("result strobe with no query outstanding: found %0b, floor_id %0h",
                 found_i, floor_id_i);
          error_count_o++;
        end else begin
          oldest_answer = floor_answers_q.pop_front();
          if (found_i !== oldest_answer.found) begin
            $error("found mismatch: expected %0b, actual %0b", oldest_answer.found, found_i);
            error_count_o++;
          end
          if (floor_id_i !== oldest_answer.floor_id) begin
            $error("floor_id mismatch: expected %0h, actual %0h",
                   oldest_answer.floor_id, floor_id_i);
            error_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (operation_i)
          OP_CLEAR: begin
            list_len = '0;
          end
          OP_APPEND: begin
            if (int'(list_len) < DEPTH) begin
              id_list[list_len[ADDR_W-1:0]] = value_i;
              list_len = list_len + 1'b1;
            end
          end
          OP_QUERY: begin
            floor_answers_q.push_back(predict_floor(value_i));
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = floor_answers_q.size();
  end

endmodule

// ----- verif/tb_sorted_floor_search_unit.sv -----
// testbench top for the floor search unit: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps
module tb_sorted_floor_search_unit import sfs_pkg::*; ();

  localparam int          CLK_PERIOD   = 12;
  localparam int          ITEM_TARGET  = 1850;
  localparam int          DRAIN_CYCLES = 40;
  localparam longint      TIMEOUT_NS   = 64'd20_000_000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          operation_i;
  logic [ID_WIDTH-1:0] value_i;
  logic                result_strobe_o;
  logic                found_o;
  logic [ID_WIDTH-1:0] floor_id_o;
  int                  error_count;
  int                  pending;

  logic [ID_WIDTH-1:0] stored_ids [$];
  int                  items;
  bit                  no_idle;
  bit                  full_done;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sorted_floor_search_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .result_strobe_o (result_strobe_o),
    .found_o         (found_o),
    .floor_id_o      (floor_id_o)
  );

  sfs_floor_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .result_strobe_i (result_strobe_o),
    .found_i         (found_o),
    .floor_id_i      (floor_id_o),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly near stored ids so equal and neighbor cases come up often
  function automatic logic [ID_WIDTH-1:0] pick_target();
    logic [ID_WIDTH-1:0] base;
    int                  r;
    r = $urandom_range(0, 99);
    if (stored_ids.size() == 0 || r < 25) return $urandom;
    base = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
    if (r < 55) return base;
    if (r < 70) return base - 1'b1;
    if (r < 85) return base + 1'b1;
    if (r < 93) return '0;
    return '1;
  endfunction

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic issue(logic [1:0] op, logic [ID_WIDTH-1:0] v);
    int gap;
    start       <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_CLEAR) begin
      stored_ids.delete();
      items++;
    end else if (op == OP_APPEND) begin
      if (stored_ids.size() < DEPTH) begin
        stored_ids.push_back(v);
        items++;
      end
    end else if (op == OP_QUERY) begin
      items++;
    end
    @(negedge clk_i);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_answers();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic fill_and_query(int n, bit narrow, bit stepped);
    logic [ID_WIDTH-1:0] vals [$];
    logic [ID_WIDTH-1:0] v;
    int                  pos;
    int                  nq;
    if (stepped) begin
      v = $urandom_range(0, 1000);
      for (int i = 0; i < n; i++) begin
        vals.push_back(v);
        v = v + ($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 1 << 21));
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        v   = narrow ? ID_WIDTH'($urandom_range(0, 63)) : ID_WIDTH'($urandom);
        pos = 0;
        while (pos < vals.size() && vals[pos] <= v) pos++;
        vals.insert(pos, v);
      end
    end
    foreach (vals[i]) begin
      if ($urandom_range(0, 99) < 4) issue(OP_UNUSED, $urandom);
      if ($urandom_range(0, 99) < 12) issue(OP_QUERY, pick_target());
      if (!stepped && $urandom_range(0, 99) < 5) issue(OP_APPEND, $urandom);
      else issue(OP_APPEND, vals[i]);
    end
    nq = stepped ? 60 : $urandom_range(1, 12);
    repeat (nq) issue(OP_QUERY, pick_target());
  endtask

  initial begin
    int r;
    int n;
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = OP_CLEAR;
    value_i     = '0;
    items       = 0;
    no_idle     = 1'b0;
    full_done   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, extremes, exact hits, between and below, unused code, out of order
    issue(OP_QUERY, '0);
    issue(OP_QUERY, '1);
    issue(OP_APPEND, '0);
    issue(OP_QUERY, '0);
    issue(OP_APPEND, 32'd5);
    issue(OP_APPEND, 32'd5);
    issue(OP_APPEND, 32'd1000);
    issue(OP_APPEND, 32'h8000_0000);
    issue(OP_APPEND, '1);
    issue(OP_QUERY, 32'd4);
    issue(OP_QUERY, 32'd5);
    issue(OP_QUERY, 32'd999);
    issue(OP_QUERY, 32'hFFFF_FFFE);
    issue(OP_QUERY, '1);
    issue(OP_UNUSED, 32'hAAAA_AAAA);
    issue(OP_QUERY, 32'h5555_5555);
    issue(OP_CLEAR, 32'h5555_5555);
    issue(OP_QUERY, 32'd7);
    issue(OP_APPEND, 32'd100);
    issue(OP_QUERY, 32'd99);
    issue(OP_APPEND, 32'd50);
    issue(OP_QUERY, 32'd60);
    issue(OP_QUERY, 32'd100);

    // hold off until the last query result is back
    start <= 1'b0;
    wait_for_answers();
    @(negedge clk_i);

    while (items < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        wait_for_answers();
        @(negedge clk_i);
      end
      if (!full_done && items > 400) begin
        full_done = 1'b1;
        issue(OP_CLEAR, $urandom);
        fill_and_query(DEPTH + $urandom_range(1, 6), 1'b0, 1'b1);
      end else begin
        if ($urandom_range(0, 4) != 0) issue(OP_CLEAR, $urandom);
        r = $urandom_range(0, 99);
        if (r < 5) n = 0;
        else if (r < 65) n = $urandom_range(1, 8);
        else if (r < 92) n = $urandom_range(9, 40);
        else n = $urandom_range(41, 150);
        fill_and_query(n, $urandom_range(0, 3) == 0, 1'b0);
      end
    end

    start <= 1'b0;
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("tb_sorted_floor_search_unit: done, clean");
    end else begin
      $display("tb_sorted_floor_search_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_sorted_floor_search_unit: done, errors");
    $finish;
  end

endmodule
